// ===== rtl/sobel_edge_magnitude_rgb_assert.svh =====
// Assertion macros used by the Sobel edge magnitude top level.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sem_pkg.sv =====
// Package with types and constants of the Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int NUM_LANES      = 3;
	localparam int CFG_W_BITS     = 11;
	localparam int CFG_H_BITS     = 13;
	localparam int ROOT_STEPS     = 8;
	localparam logic [21:0] SQ_LIMIT = 22'd65280;
	localparam logic [7:0]  MAG_SAT  = 8'd255;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} pixel_item_t;

	typedef struct packed {
		logic [7:0] edge_red;
		logic [7:0] edge_green;
		logic [7:0] edge_blue;
		logic       frame_last;
	} edge_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lane_stat_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_WIN,
		T_CALC,
		T_HOLD
	} top_state_t;

	typedef enum logic [2:0] {
		LN_IDLE,
		LN_SQUARE,
		LN_SUM,
		LN_ROOT,
		LN_ROUND
	} lane_state_t;

endpackage
`default_nettype wire

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// Top level of the streaming RGB Sobel edge magnitude block.
// An item that yields a result passes the T_WIN, T_CALC and T_HOLD states before edge_valid shows it.
// The block takes no new item until the last one is back in T_IDLE; an ignored flush never leaves T_IDLE.
// Most of T_CALC is spent in the eight-step square root iteration in the three colour lanes.
// Reset clears counters, window and handshake state; line memories are not cleared.
// Configuration resets to a 1x1 frame; a register write holds off input in the cycle after it.
`timescale 1ns / 1ps
`default_nettype none
`include "sobel_edge_magnitude_rgb_assert.svh"
module sobel_edge_magnitude_rgb
	import sem_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pixel_valid,
	output logic             pixel_ready,
	input  wire pixel_item_t pixel_item,
	output logic             edge_valid,
	input  wire logic        edge_ready,
	output edge_item_t       edge_item,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int PW  = WW + HW + 1;
	localparam int CWW = (WW > CFG_W_BITS) ? WW : CFG_W_BITS;
	localparam int CHW = (HW > CFG_H_BITS) ? HW : CFG_H_BITS;

	logic [CFG_W_BITS-1:0] cfg_w_q;
	logic [CFG_H_BITS-1:0] cfg_h_q;
	logic [WW-1:0]         eff_w;
	logic [HW-1:0]         eff_h;
	logic [WW+HW-1:0]      total_q;
	logic                  cfg_we;
	logic                  cfg_hold_q;

	top_state_t state_q, state_d;
	logic [PW-1:0] p_q;
	logic [XW-1:0] col_q;
	logic [XW-1:0] out_col_q;
	logic [HW-1:0] out_row_q;
	logic [23:0]   win_q [3][3];

	logic          take, ignore, in_frame, advance;
	logic [23:0]   v_s1;
	logic [XW-1:0] x_s1;
	logic          emit_s1, last_s1;
	logic [23:0]   top_rd, mid_rd;

	logic                      lane_start, lanes_done, out_load, restart;
	logic [2:0][2:0]           mask;
	logic [2:0][2:0][7:0]      lane_win [NUM_LANES];
	lane_stat_t                lane_stat [NUM_LANES];
	logic [7:0]                lane_mag [NUM_LANES];
	logic                      edge_valid_q;
	edge_item_t                edge_q;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = paddr[2] ? 32'(cfg_h_q) : 32'(cfg_w_q);

	always_comb begin
		if (cfg_w_q == '0) begin
			eff_w = WW'(1);
		end else if (CWW'(cfg_w_q) > CWW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(cfg_w_q);
		end
		if (cfg_h_q == '0) begin
			eff_h = HW'(1);
		end else if (CHW'(cfg_h_q) > CHW'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(cfg_h_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q    <= CFG_W_BITS'(1);
			cfg_h_q    <= CFG_H_BITS'(1);
			total_q    <= (WW + HW)'(1);
			cfg_hold_q <= 1'b0;
		end else begin
			total_q    <= (WW + HW)'(eff_w) * (WW + HW)'(eff_h);
			cfg_hold_q <= cfg_we;
			if (cfg_we) begin
				case (paddr[2])
					REG_FRAME_WIDTH:  cfg_w_q <= pwdata[CFG_W_BITS-1:0];
					REG_FRAME_HEIGHT: cfg_h_q <= pwdata[CFG_H_BITS-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	assign take     = pixel_valid && pixel_ready;
	assign in_frame = p_q < PW'(total_q);
	assign ignore   = (pixel_item.kind == KIND_FLUSH) && in_frame;
	assign advance  = take && !ignore;

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE:  if (advance) state_d = T_WIN;
			T_WIN:   state_d = emit_s1 ? T_CALC : T_IDLE;
			T_CALC:  if (lanes_done) state_d = T_HOLD;
			T_HOLD:  if (out_load) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		pixel_ready = (state_q == T_IDLE) && !cfg_hold_q;
		lane_start  = (state_q == T_WIN) && emit_s1;
		lanes_done  = (state_q == T_CALC) && lane_stat[0].done;
		out_load    = (state_q == T_HOLD) && (!edge_valid_q || edge_ready);
		restart     = cfg_we || (lanes_done && last_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			v_s1    <= in_frame ? {pixel_item.pixel_red, pixel_item.pixel_green,
				pixel_item.pixel_blue} : 24'd0;
			x_s1    <= col_q;
			emit_s1 <= p_q >= PW'(eff_w) + PW'(1);
			last_s1 <= p_q >= PW'(total_q) + PW'(eff_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q       <= '0;
			col_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			p_q       <= '0;
			col_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (advance) begin
				p_q <= p_q + PW'(1);
				if (WW'(col_q) + WW'(1) >= eff_w) begin
					col_q <= '0;
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
			if (lanes_done) begin
				if (WW'(out_col_q) + WW'(1) >= eff_w) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + HW'(1);
				end else begin
					out_col_q <= out_col_q + XW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= 24'd0;
				end
			end
		end else if (restart) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= 24'd0;
				end
			end
		end else if (state_q == T_WIN) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= top_rd;
			win_q[1][2] <= mid_rd;
			win_q[2][2] <= v_s1;
		end
	end

	sem_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk    (clk),
		.rd_en  (advance),
		.rd_addr(col_q),
		.wr_en  (state_q == T_WIN),
		.wr_addr(x_s1),
		.wr_top (mid_rd),
		.wr_mid (v_s1),
		.top_rd (top_rd),
		.mid_rd (mid_rd)
	);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mask[0][j] = (out_row_q != '0);
			mask[1][j] = 1'b1;
			mask[2][j] = ((HW + 1)'(out_row_q) + (HW + 1)'(1)) < (HW + 1)'(eff_h);
		end
		for (int i = 0; i < 3; i++) begin
			mask[i][0] = mask[i][0] && (out_col_q != '0);
			mask[i][2] = mask[i][2] && ((WW'(out_col_q) + WW'(1)) < eff_w);
		end
	end

	for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
		for (genvar i = 0; i < 3; i++) begin : g_row
			for (genvar j = 0; j < 3; j++) begin : g_col
				assign lane_win[c][i][j] = win_q[i][j][8*(NUM_LANES-1-c) +: 8];
			end
		end
		sem_lane u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.start (lane_start),
			.win   (lane_win[c]),
			.mask  (mask),
			.stat  (lane_stat[c]),
			.mag   (lane_mag[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_valid_q <= 1'b0;
		end else if (out_load) begin
			edge_valid_q <= 1'b1;
		end else if (edge_ready) begin
			edge_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			edge_q.edge_red   <= lane_mag[0];
			edge_q.edge_green <= lane_mag[1];
			edge_q.edge_blue  <= lane_mag[2];
			edge_q.frame_last <= last_s1;
		end
	end

	assign edge_valid = edge_valid_q;
	assign edge_item  = edge_q;

	`SEM_ASSERT_IMP(a_lanes_in_step, clk, arst_n, lane_stat[0].done,
		lane_stat[1].done && lane_stat[2].done, "Colour lanes finished out of step.")
	`SEM_ASSERT_IMP(a_start_when_idle, clk, arst_n, lane_start,
		!lane_stat[0].busy && !lane_stat[1].busy && !lane_stat[2].busy,
		"Lane started while busy.")
	`SEM_ASSERT_NXT(a_done_to_hold, clk, arst_n, lanes_done, state_q == T_HOLD,
		"Finished result not held for output.")
	`SEM_ASSERT_NXT(a_load_sets_valid, clk, arst_n, out_load, edge_valid_q,
		"Output register not marked valid after load.")

endmodule
`default_nettype wire

// ===== rtl/sem_line_buf.sv =====
// Two line memories holding the previous two image rows.
`timescale 1ns / 1ps
`default_nettype none
module sem_line_buf
	import sem_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [23:0]              wr_top,
	input  wire logic [23:0]              wr_mid,
	output logic      [23:0]              top_rd,
	output logic      [23:0]              mid_rd
);

	logic [23:0] top_mem [DEPTH];
	logic [23:0] mid_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			top_rd <= top_mem[rd_addr];
			mid_rd <= mid_mem[rd_addr];
		end
		if (wr_en) begin
			top_mem[wr_addr] <= wr_top;
			mid_mem[wr_addr] <= wr_mid;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sem_lane.sv =====
// One colour lane: Sobel gradients, squared sum and rounded square root.
`timescale 1ns / 1ps
`default_nettype none
module sem_lane
	import sem_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [2:0][2:0][7:0]  win,
	input  wire logic [2:0][2:0]       mask,
	output lane_stat_t                 stat,
	output logic [7:0]                 mag
);

	lane_state_t state_q, state_d;
	logic signed [11:0] a [3][3];
	logic signed [11:0] gx, gy;
	logic signed [23:0] px, py;
	logic [20:0] sqx_q, sqy_q;
	logic [21:0] s_q;
	logic [7:0]  r_q;
	logic [15:0] r2_q;
	logic [2:0]  k_q;
	logic [17:0] t2;
	logic [21:0] diff;
	logic [7:0]  mag_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				a[i][j] = mask[i][j] ? $signed({4'b0, win[i][j]}) : 12'sd0;
			end
		end
		gx = (a[0][2] - a[0][0]) + ((a[1][2] - a[1][0]) <<< 1) + (a[2][2] - a[2][0]);
		gy = (a[2][0] - a[0][0]) + ((a[2][1] - a[0][1]) <<< 1) + (a[2][2] - a[0][2]);
		px = gx * gx;
		py = gy * gy;
		t2 = 18'(r2_q) + (18'(r_q) << (4'(k_q) + 4'd1)) + (18'd1 << (5'(k_q) << 1));
		diff = s_q - 22'(r2_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			LN_IDLE:   if (start) state_d = LN_SQUARE;
			LN_SQUARE: state_d = LN_SUM;
			LN_SUM:    state_d = LN_ROOT;
			LN_ROOT:   if (k_q == 3'd0) state_d = LN_ROUND;
			LN_ROUND:  state_d = LN_IDLE;
			default:   state_d = LN_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = (state_q != LN_IDLE);
		stat.done = (state_q == LN_ROUND);
		mag       = mag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			LN_SQUARE: begin
				sqx_q <= px[20:0];
				sqy_q <= py[20:0];
			end
			LN_SUM: begin
				s_q  <= 22'(sqx_q) + 22'(sqy_q);
				r_q  <= 8'd0;
				r2_q <= 16'd0;
				k_q  <= 3'(ROOT_STEPS - 1);
			end
			LN_ROOT: begin
				if (22'(t2) <= s_q) begin
					r_q  <= r_q | (8'd1 << k_q);
					r2_q <= t2[15:0];
				end
				k_q <= k_q - 3'd1;
			end
			LN_ROUND: begin
				if (s_q > SQ_LIMIT) begin
					mag_q <= MAG_SAT;
				end else if (diff > 22'(r_q)) begin
					mag_q <= r_q + 8'd1;
				end else begin
					mag_q <= r_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the streaming RGB Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import sem_pkg::*;

	localparam int MAXW = 1024;
	localparam int MAXH = 4096;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	pixel_item_t pixel_item = '0;
	logic edge_valid;
	logic edge_ready = 1'b0;
	edge_item_t edge_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	sobel_edge_magnitude_rgb uut (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel_item(pixel_item),
		.edge_valid(edge_valid), .edge_ready(edge_ready), .edge_item(edge_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pixel_item_t pending_pixels[$];
	edge_item_t expected_edges[$];
	int errors = 0;
	bit calm = 1'b0;
	int hold_cycles = 0;

	logic [10:0] width_reg;
	logic [12:0] height_reg;
	logic [23:0] line_mem[0:2*MAXW-1];
	logic [23:0] win[3][3];
	int in_col, in_row, out_col, out_row;

	function automatic int eff_w();
		if (width_reg == 0) return 1;
		if (width_reg > MAXW) return MAXW;
		return width_reg;
	endfunction

	function automatic int eff_h();
		if (height_reg == 0) return 1;
		if (height_reg > MAXH) return MAXH;
		return height_reg;
	endfunction

	task automatic restart_frame();
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endtask

	function automatic logic [7:0] rounded_root(int s);
		int r;
		int t;
		r = 0;
		if (s > 65280) return 8'd255;
		for (int b = 128; b != 0; b >>= 1) begin
			t = r + b;
			if (t * t <= s) r = t;
		end
		if (s - r * r > r) r++;
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	function automatic logic [7:0] lane_gradient(int shift, bit ok[3][3]);
		int kx[3][3];
		int ky[3][3];
		int gx;
		int gy;
		int v;
		kx = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
		ky = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
		gx = 0;
		gy = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (ok[i][j]) begin
					v = (win[i][j] >> shift) & 8'hFF;
					gx += v * kx[i][j];
					gy += v * ky[i][j];
				end
		return rounded_root(gx * gx + gy * gy);
	endfunction

	task automatic predict_edge(pixel_item_t it);
		int w;
		int h;
		int total;
		int p;
		int x;
		int q;
		logic [23:0] v;
		logic [23:0] top;
		logic [23:0] mid;
		bit ok[3][3];
		edge_item_t e;
		w = eff_w();
		h = eff_h();
		total = w * h;
		p = in_row * w + in_col;
		v = '0;
		if (it.kind == KIND_FLUSH && p < total) return;
		if (p < total) v = {it.pixel_red, it.pixel_green, it.pixel_blue};
		x = (in_col < MAXW) ? in_col : 0;
		top = line_mem[MAXW + x];
		mid = line_mem[x];
		line_mem[MAXW + x] = mid;
		line_mem[x] = v;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = v;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (p < w + 1) return;
		q = p - (w + 1);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				ok[i][j] = (out_row + i >= 1) && (out_row + i <= h)
					&& (out_col + j >= 1) && (out_col + j <= w);
		e.edge_red = lane_gradient(16, ok);
		e.edge_green = lane_gradient(8, ok);
		e.edge_blue = lane_gradient(0, ok);
		e.frame_last = (q + 1 >= total);
		expected_edges.push_back(e);
		if (q + 1 >= total) restart_frame();
		else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

	int send_gap = 0;
	always @(posedge clk) begin
		if (pixel_valid && pixel_ready) begin
			predict_edge(pixel_item);
		end
		if (!pixel_valid || pixel_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				pixel_valid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				pixel_item <= pending_pixels.pop_front();
				pixel_valid <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 14);
			end else begin
				pixel_valid <= 1'b0;
			end
		end
	end

	int recv_gap = 0;
	always @(posedge clk) begin
		if (edge_valid && edge_ready) begin
			if (expected_edges.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h", $time, edge_item);
				errors++;
			end else if (expected_edges[0] !== edge_item) begin
				$display("%0t: mismatch, expected %h actual %h", $time,
					expected_edges[0], edge_item);
				errors++;
				void'(expected_edges.pop_front());
			end else begin
				void'(expected_edges.pop_front());
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			edge_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			edge_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			recv_gap <= $urandom_range(0, 13);
			edge_ready <= 1'b0;
		end else begin
			edge_ready <= 1'b1;
		end
	end

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == 3'd0) width_reg = data[10:0];
		else if (addr == 3'd4) height_reg = data[12:0];
		if (addr == 3'd0 || addr == 3'd4) restart_frame();
	endtask

	task automatic drain();
		while (pending_pixels.size() > 0 || pixel_valid || expected_edges.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic pixel_item_t rand_pixel();
		pixel_item_t it;
		it.kind = KIND_PIXEL;
		it.pixel_red = 8'($urandom);
		it.pixel_green = 8'($urandom);
		it.pixel_blue = 8'($urandom);
		return it;
	endfunction

	task automatic queue_frame(int w, int h, bit extremes, bit noise);
		pixel_item_t it;
		int n;
		n = 0;
		while (n < w * h) begin
			it = rand_pixel();
			if (extremes) begin
				it.pixel_red = (n % 2) ? 8'hFF : 8'h00;
				it.pixel_green = (n % 3) ? 8'h00 : 8'hFF;
				it.pixel_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			if (noise && $urandom_range(0, 19) == 0) begin
				it.kind = KIND_FLUSH;
			end else begin
				n++;
			end
			pending_pixels.push_back(it);
		end
		for (int k = 0; k < w + 1; k++) begin
			it = rand_pixel();
			if ($urandom_range(0, 3) != 0) it.kind = KIND_FLUSH;
			pending_pixels.push_back(it);
		end
	endtask

	int sent;
	int fw;
	int fh;
	pixel_item_t tail_it;

	initial begin
		width_reg = 11'd1;
		height_reg = 13'd1;
		for (int i = 0; i < 2 * MAXW; i++) line_mem[i] = '0;
		restart_frame();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		queue_frame(1, 1, 1'b1, 1'b0);
		drain();
		write_reg(3'd0, 32'd3);
		write_reg(3'd4, 32'd3);
		queue_frame(3, 3, 1'b1, 1'b1);
		drain();
		write_reg(3'd0, 32'd0);
		write_reg(3'd4, 32'd4);
		queue_frame(1, 4, 1'b0, 1'b0);
		drain();
		write_reg(3'd0, 32'd4);
		write_reg(3'd4, 32'd1);
		hold_cycles = 60;
		queue_frame(4, 1, 1'b1, 1'b0);
		drain();

		sent = 0;
		while (sent < 220) begin
			fw = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
			fh = $urandom_range(1, 8);
			if ($urandom_range(0, 5) == 0) begin
				write_reg(3'd0, {$urandom} & 32'h7FF & (($urandom_range(0, 1) ? 32'h7FF : 32'h0)));
			end
			write_reg(3'd0, fw);
			write_reg(3'd4, fh);
			if (sent > 40 && sent < 120) hold_cycles = 200;
			queue_frame(fw, fh, 1'b0, 1'b1);
			sent += fw * fh + fw + 1;
			drain();
		end

		calm = 1'b1;
		write_reg(3'd0, 32'd2047);
		write_reg(3'd4, 32'd1);
		for (int k = 0; k < MAXW; k++) pending_pixels.push_back(rand_pixel());
		for (int k = 0; k < 3; k++) begin
			tail_it = rand_pixel();
			tail_it.kind = KIND_FLUSH;
			pending_pixels.push_back(tail_it);
		end
		drain();
		write_reg(3'd4, 32'd8191);
		write_reg(3'd0, 32'd1);
		write_reg(3'd4, 32'd2);
		write_reg(3'd0, 32'd2);
		queue_frame(2, 2, 1'b1, 1'b0);
		drain();

		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
